/* rtl/fdc_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the frame decoder.
// No dependencies; used by fdc_parser, fdc_skid and frame_decoder_crc16_check.
`default_nettype none

package fdc_pkg;

    // Header layout: byte positions within the 12-byte header.
    localparam logic [3:0] HEADER_BYTES = 4'd12;
    localparam logic [3:0] VERSION_POS  = 4'd4;
    localparam logic [3:0] TYPE_POS     = 4'd5;
    localparam logic [3:0] LENGTH_END   = 4'd10;

    // CRC-16/CCITT-FALSE constants.
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Frame verdict codes.
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SMALL    = 3'd1,
        ST_BAD_MAGIC    = 3'd2,
        ST_BAD_VERSION  = 3'd3,
        ST_TOO_SHORT    = 3'd4,
        ST_CRC_MISMATCH = 3'd5
    } t_status;

    // One result item as it travels to the output port.
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        status_valid;
        t_status     frame_status;
        logic [7:0]  message_type;
        logic [31:0] payload_length;
    } t_result;

    // Feed one byte into the CRC, MSB first, eight shift steps unrolled.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

/* rtl/fdc_parser.sv */
// Header parser, payload pass-through and CRC check for one byte per cycle while i_accept is high.
// Depends on fdc_pkg; the result is registered downstream in fdc_skid.
`default_nettype none

module fdc_parser
    import fdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_buffer_end,
    input  wire logic [31:0] i_magic_word,
    input  wire logic [7:0]  i_expected_version,
    output logic             o_res_valid,
    output t_result          o_res
);

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_MAGIC   = 2'd1;
    localparam logic [1:0] FAULT_VERSION = 2'd2;

    logic [3:0]  r_pos,       n_pos;
    logic [1:0]  r_fault,     n_fault;
    logic [7:0]  r_type,      n_type;
    logic [31:0] r_length,    n_length;
    logic [31:0] r_left,      n_left;
    logic [15:0] r_crc_exp,   n_crc_exp;
    logic [15:0] r_crc,       n_crc;
    logic        r_done,      n_done;

    logic        pay;
    logic        verdict;
    t_status     status;
    logic [1:0]  magic_sel;
    logic [7:0]  magic_want;
    logic        too_small;

    // Expected magic byte for the current header position, first byte on top.
    assign magic_sel  = 2'd3 - r_pos[1:0];
    assign magic_want = i_magic_word[{magic_sel, 3'b000} +: 8];

    // Next state and verdict for the byte on the input.
    always_comb begin
        n_pos     = r_pos;
        n_fault   = r_fault;
        n_type    = r_type;
        n_length  = r_length;
        n_left    = r_left;
        n_crc_exp = r_crc_exp;
        n_crc     = r_crc;
        n_done    = r_done;
        pay       = 1'b0;
        verdict   = 1'b0;
        status    = ST_OK;

        if (!r_done) begin
            if (r_pos < HEADER_BYTES) begin
                if (r_pos < VERSION_POS) begin
                    if (i_data_byte != magic_want && r_fault == FAULT_NONE) begin
                        n_fault = FAULT_MAGIC;
                    end
                end else if (r_pos == VERSION_POS) begin
                    if (i_data_byte != i_expected_version && r_fault == FAULT_NONE) begin
                        n_fault = FAULT_VERSION;
                    end
                end else if (r_pos == TYPE_POS) begin
                    n_type = i_data_byte;
                end else if (r_pos < LENGTH_END) begin
                    n_length = {r_length[23:0], i_data_byte};
                end else begin
                    n_crc_exp = {r_crc_exp[7:0], i_data_byte};
                end
                n_pos = r_pos + 4'd1;
                if (n_pos == HEADER_BYTES) begin
                    n_left = n_length;
                end
            end else if (r_fault == FAULT_NONE && r_left != 32'd0) begin
                pay    = 1'b1;
                n_crc  = crc16_byte(r_crc, i_data_byte);
                n_left = r_left - 32'd1;
            end

            if (n_pos == HEADER_BYTES && (n_fault != FAULT_NONE || n_left == 32'd0)) begin
                verdict = 1'b1;
                case (n_fault)
                    FAULT_MAGIC:   status = ST_BAD_MAGIC;
                    FAULT_VERSION: status = ST_BAD_VERSION;
                    default:       status = (n_crc == n_crc_exp) ? ST_OK : ST_CRC_MISMATCH;
                endcase
            end else if (i_buffer_end) begin
                verdict = 1'b1;
                status  = (n_pos < HEADER_BYTES) ? ST_TOO_SMALL : ST_TOO_SHORT;
            end
            if (verdict) begin
                n_done = 1'b1;
            end
        end

        // The byte marked as the buffer's end returns all frame state to reset.
        if (i_buffer_end) begin
            n_pos     = 4'd0;
            n_fault   = FAULT_NONE;
            n_type    = 8'd0;
            n_length  = 32'd0;
            n_left    = 32'd0;
            n_crc_exp = 16'd0;
            n_crc     = CRC_INIT;
            n_done    = 1'b0;
        end
    end

    // Result item for this byte.
    assign too_small   = verdict && (status == ST_TOO_SMALL);
    assign o_res_valid = i_accept && (pay || verdict);

    always_comb begin
        o_res.payload_byte   = pay ? i_data_byte : 8'd0;
        o_res.payload_valid  = pay;
        o_res.status_valid   = verdict;
        o_res.frame_status   = verdict ? status : ST_OK;
        // Header fields are taken after this byte's update, before the
        // end-of-buffer clear.
        o_res.message_type   = too_small ? 8'd0
                             : (r_pos == TYPE_POS ? i_data_byte : r_type);
        o_res.payload_length = too_small ? 32'd0
                             : ((r_pos > TYPE_POS && r_pos < LENGTH_END)
                                ? {r_length[23:0], i_data_byte} : r_length);
    end

    // Frame state advances on every transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 4'd0;
            r_fault   <= FAULT_NONE;
            r_type    <= 8'd0;
            r_length  <= 32'd0;
            r_left    <= 32'd0;
            r_crc_exp <= 16'd0;
            r_crc     <= CRC_INIT;
            r_done    <= 1'b0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_fault   <= n_fault;
            r_type    <= n_type;
            r_length  <= n_length;
            r_left    <= n_left;
            r_crc_exp <= n_crc_exp;
            r_crc     <= n_crc;
            r_done    <= n_done;
        end
    end

endmodule

`default_nettype wire

/* rtl/fdc_skid.sv */
// Output register with one skid entry for result items.
// Depends on fdc_pkg for the result type.
`default_nettype none

module fdc_skid
    import fdc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_result  i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_result       o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    out_free;

    // The upstream side may send while the skid entry is empty.
    assign o_ready  = !r_skid_valid;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;

    // Occupancy of the two entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_valid;
            r_skid_valid <= 1'b0;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload of the two entries.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_valid) begin
            r_skid_data <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/frame_decoder_crc16_check.sv */
// Top level of the length-prefixed frame decoder with CRC-16 check.
// Depends on fdc_pkg, fdc_parser and fdc_skid.
//
// Usage:
//   The input channel takes one buffer byte per transfer, with i_buffer_end
//   set on the buffer's last byte. The first 12 bytes are the header: magic,
//   version, message type, 32-bit length and 16-bit CRC, all big-endian.
//   The output channel carries zero or one result per byte: a payload byte,
//   the frame verdict, or both, along with the header's type and length.
//   A result is registered in the output register, or in the skid entry while
//   the receiver stalls, when its byte is transferred. Throughput is one byte
//   per cycle while input ready is high, set by the combinational CRC byte
//   update and header compare between the input and the output register.
//   When the receiver stalls, one result is held in the output register and
//   one more in the skid entry; input ready drops only while both are full.
//   Reset (synchronous, active low) clears the frame state, empties the
//   output stage and sets magic_word to 0 and expected_version to 1.
//   Configuration writes take effect on the clock edge with i_cfg_we high.
`default_nettype none

module frame_decoder_crc16_check
    import fdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // Input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_buffer_end,
    // Output channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_payload_byte,
    output logic             o_payload_valid,
    output logic             o_status_valid,
    output logic [2:0]       o_frame_status,
    output logic [7:0]       o_message_type,
    output logic [31:0]      o_payload_length
);

    localparam logic CFG_MAGIC   = 1'b0;
    localparam logic CFG_VERSION = 1'b1;

    logic [31:0] r_magic_word;
    logic [7:0]  r_expected_version;
    logic        accept;
    logic        res_valid;
    t_result     res;
    t_result     out_res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word       <= 32'd0;
            r_expected_version <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAGIC:   r_magic_word       <= i_cfg_data;
                CFG_VERSION: r_expected_version <= i_cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    assign accept = i_in_valid && o_in_ready;

    fdc_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_data_byte        (i_data_byte),
        .i_buffer_end       (i_buffer_end),
        .i_magic_word       (r_magic_word),
        .i_expected_version (r_expected_version),
        .o_res_valid        (res_valid),
        .o_res              (res)
    );

    fdc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (o_in_ready),
        .i_data  (res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_res)
    );

    // Result fields to the ports.
    assign o_payload_byte   = out_res.payload_byte;
    assign o_payload_valid  = out_res.payload_valid;
    assign o_status_valid   = out_res.status_valid;
    assign o_frame_status   = out_res.frame_status;
    assign o_message_type   = out_res.message_type;
    assign o_payload_length = out_res.payload_length;

`ifndef SYNTHESIS
    // A result always carries a payload byte or a verdict.
    a_result_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_payload_valid || o_status_valid))
        else $error("empty result item");

    // The status field is zero unless a verdict is given.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_status_valid) |-> (o_frame_status == ST_OK))
        else $error("status without verdict");

    // A short header reports no header fields.
    a_small_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status_valid && o_frame_status == ST_TOO_SMALL)
        |-> (o_message_type == 8'd0 && o_payload_length == 32'd0 && !o_payload_valid))
        else $error("too_small result carries header fields");

    // Input is held off only while the output register is occupied.
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire

/* tb/frame_decoder_crc16_check_tb.sv */
// Self-checking testbench for the frame decoder with CRC-16 check.
// Depends on fdc_pkg and frame_decoder_crc16_check; a built-in frame decoder
// model predicts each result, and the checker compares every output field.
`timescale 1ns / 1ps

module frame_decoder_crc16_check_tb;
    import fdc_pkg::*;

    // Register indexes of the configuration port.
    localparam logic REG_MAGIC   = 1'b0;
    localparam logic REG_VERSION = 1'b1;

    // One buffer byte waiting to be sent.
    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } t_byte_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_buffer_end;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_payload_byte;
    logic        o_payload_valid;
    logic        o_status_valid;
    logic [2:0]  o_frame_status;
    logic [7:0]  o_message_type;
    logic [31:0] o_payload_length;

    // Stimulus and result stores.
    t_byte_item  byte_q [$];
    t_result     decoded_q [$];
    int unsigned queued_bytes = 0;
    int unsigned error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        byte_taken = 1'b0;

    // Register copies and per-buffer state of the decoder model.
    logic [31:0] magic_reg = 32'h0000_0000;
    logic [7:0]  version_reg = 8'h01;
    logic [3:0]  hdr_pos = 4'd0;
    t_status     hdr_fault = ST_OK;
    logic [7:0]  type_hold = 8'h00;
    logic [31:0] len_hold = 32'h0;
    logic [31:0] bytes_left = 32'h0;
    logic [15:0] crc_want = 16'h0000;
    logic [15:0] crc_run = CRC_INIT;
    logic        verdict_sent = 1'b0;

    frame_decoder_crc16_check uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_buffer_end     (i_buffer_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_payload_byte   (o_payload_byte),
        .o_payload_valid  (o_payload_valid),
        .o_status_valid   (o_status_valid),
        .o_frame_status   (o_frame_status),
        .o_message_type   (o_message_type),
        .o_payload_length (o_payload_length)
    );

    // 100 MHz clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // CRC-16/CCITT-FALSE, one input bit at a time, MSB first.
    function automatic logic [15:0] crc_ccitt_update(input logic [15:0] crc_in,
                                                     input logic [7:0] data);
        logic [15:0] crc;
        logic        fb;
        crc = crc_in;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ data[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    // Decoder model: advance the frame state by one byte and queue the
    // result it produces, if any.
    function automatic void decode_byte(input logic [7:0] b, input logic is_last);
        t_result     r;
        logic        pay;
        logic        verdict;
        t_status     st;
        logic [31:0] magic_left;
        pay     = 1'b0;
        verdict = 1'b0;
        st      = ST_OK;
        if (!verdict_sent) begin
            if (hdr_pos < HEADER_BYTES) begin
                if (hdr_pos < VERSION_POS) begin
                    magic_left = magic_reg << (8 * hdr_pos);
                    if (b != magic_left[31:24] && hdr_fault == ST_OK) begin
                        hdr_fault = ST_BAD_MAGIC;
                    end
                end else if (hdr_pos == VERSION_POS) begin
                    if (b != version_reg && hdr_fault == ST_OK) begin
                        hdr_fault = ST_BAD_VERSION;
                    end
                end else if (hdr_pos == TYPE_POS) begin
                    type_hold = b;
                end else if (hdr_pos < LENGTH_END) begin
                    len_hold = {len_hold[23:0], b};
                end else begin
                    crc_want = {crc_want[7:0], b};
                end
                hdr_pos = hdr_pos + 4'd1;
                if (hdr_pos == HEADER_BYTES) begin
                    bytes_left = len_hold;
                end
            end else if (hdr_fault == ST_OK && bytes_left != 0) begin
                pay        = 1'b1;
                crc_run    = crc_ccitt_update(crc_run, b);
                bytes_left = bytes_left - 32'd1;
            end

            // The verdict comes as soon as it is decided, or at buffer end.
            if (hdr_pos == HEADER_BYTES && (hdr_fault != ST_OK || bytes_left == 0)) begin
                verdict = 1'b1;
                if (hdr_fault != ST_OK) begin
                    st = hdr_fault;
                end else if (crc_run != crc_want) begin
                    st = ST_CRC_MISMATCH;
                end
            end else if (is_last) begin
                verdict = 1'b1;
                if (hdr_pos < HEADER_BYTES) begin
                    st = ST_TOO_SMALL;
                end else begin
                    st = ST_TOO_SHORT;
                end
            end
        end

        if (pay || verdict) begin
            r.payload_byte  = pay ? b : 8'h00;
            r.payload_valid = pay;
            r.status_valid  = verdict;
            r.frame_status  = st;
            if (verdict && st == ST_TOO_SMALL) begin
                r.message_type   = 8'h00;
                r.payload_length = 32'h0;
            end else begin
                r.message_type   = type_hold;
                r.payload_length = len_hold;
            end
            decoded_q.push_back(r);
        end
        if (verdict) begin
            verdict_sent = 1'b1;
        end

        // Every buffer starts from a clean header state.
        if (is_last) begin
            hdr_pos      = 4'd0;
            hdr_fault    = ST_OK;
            type_hold    = 8'h00;
            len_hold     = 32'h0;
            bytes_left   = 32'h0;
            crc_want     = 16'h0000;
            crc_run      = CRC_INIT;
            verdict_sent = 1'b0;
        end
    endfunction

    // Print one mismatch line (the first 40 only) and count it.
    task automatic report_mismatch(input string what);
        if (error_count < 40) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        error_count++;
    endtask

    // Queue a list of bytes as one buffer, marking its last byte.
    task automatic push_buffer(input logic [7:0] bytes [$]);
        t_byte_item item;
        foreach (bytes[i]) begin
            item.value   = bytes[i];
            item.is_last = (i == bytes.size() - 1);
            byte_q.push_back(item);
            queued_bytes++;
        end
    endtask

    // Build one buffer: header, pay_cnt random payload bytes and trail extra
    // bytes. A nonzero keep cuts the buffer down to that many bytes.
    task automatic queue_frame(input logic [31:0] magic, input logic [7:0] version,
                               input logic [31:0] declared_len, input int unsigned pay_cnt,
                               input bit crc_good, input int unsigned trail,
                               input int unsigned keep);
        logic [7:0]  frame [$];
        logic [7:0]  payload [$];
        logic [7:0]  b;
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < pay_cnt; i++) begin
            b = 8'($urandom);
            payload.push_back(b);
            crc = crc_ccitt_update(crc, b);
        end
        if (!crc_good) begin
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        end
        frame = {magic[31:24], magic[23:16], magic[15:8], magic[7:0], version,
                 8'($urandom), declared_len[31:24], declared_len[23:16],
                 declared_len[15:8], declared_len[7:0], crc[15:8], crc[7:0]};
        foreach (payload[i]) begin
            frame.push_back(payload[i]);
        end
        repeat (trail) begin
            frame.push_back(8'($urandom));
        end
        while (keep != 0 && frame.size() > keep) begin
            void'(frame.pop_back());
        end
        push_buffer(frame);
    endtask

    // One random buffer: mostly well-formed frames, the rest faulty or noise.
    task automatic queue_random_frame();
        int unsigned  sel;
        int unsigned  len;
        int unsigned  trail;
        logic [7:0]   noise [$];
        sel   = $urandom_range(0, 99);
        len   = $urandom_range(0, 16);
        trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (sel < 60) begin
            queue_frame(magic_reg, version_reg, len, len, $urandom_range(0, 6) != 0, trail, 0);
        end else if (sel < 68) begin
            queue_frame(magic_reg ^ (32'h1 << $urandom_range(0, 31)),
                        ($urandom_range(0, 1) != 0) ? version_reg
                            : version_reg ^ 8'($urandom_range(1, 255)),
                        len, len, 1'b1, trail, 0);
        end else if (sel < 74) begin
            queue_frame(magic_reg, version_reg ^ 8'($urandom_range(1, 255)),
                        len, len, 1'b1, trail, 0);
        end else if (sel < 82) begin
            queue_frame(($urandom_range(0, 1) != 0) ? magic_reg : $urandom, version_reg,
                        len, len, 1'b1, 0, $urandom_range(1, 11));
        end else if (sel < 92) begin
            // Payload cut off before the declared length.
            queue_frame(magic_reg, version_reg,
                        ($urandom_range(0, 1) != 0) ? $urandom : len + $urandom_range(1, 8),
                        len, 1'b1, 0, 0);
        end else begin
            repeat ($urandom_range(1, 20)) begin
                noise.push_back(8'($urandom));
            end
            push_buffer(noise);
        end
    endtask

    // Wait until every byte is sent and every result has arrived, then
    // allow for the output latency.
    task automatic wait_drained();
        while (byte_q.size() != 0 || i_in_valid || decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Write one configuration register while the block is idle.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MAGIC) begin
            magic_reg = value;
        end else begin
            version_reg = value[7:0];
        end
    endtask

    // Random stimulus under one idling profile; the drain at the end also
    // holds the next phase off until every result has come back.
    task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
                             input int unsigned target);
        int unsigned start;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        start          = queued_bytes;
        while (queued_bytes - start < target) begin
            queue_random_frame();
        end
        wait_drained();
    endtask

    // Driver: present the next byte once the current one is transferred.
    always @(negedge i_clk) begin
        t_byte_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || byte_taken) begin
            if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = byte_q.pop_front();
                i_in_valid   <= 1'b1;
                i_data_byte  <= nxt.value;
                i_buffer_end <= nxt.is_last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: check each result transfer, then feed each byte transfer to
    // the model.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("result with none pending, status_valid %0b",
                                              o_status_valid));
                end else begin
                    want = decoded_q.pop_front();
                    if (o_payload_byte !== want.payload_byte)
                        report_mismatch($sformatf("payload_byte %0h, expected %0h",
                                                  o_payload_byte, want.payload_byte));
                    if (o_payload_valid !== want.payload_valid)
                        report_mismatch($sformatf("payload_valid %0b, expected %0b",
                                                  o_payload_valid, want.payload_valid));
                    if (o_status_valid !== want.status_valid)
                        report_mismatch($sformatf("status_valid %0b, expected %0b",
                                                  o_status_valid, want.status_valid));
                    if (o_frame_status !== want.frame_status)
                        report_mismatch($sformatf("frame_status %0d, expected %0d",
                                                  o_frame_status, want.frame_status));
                    if (o_message_type !== want.message_type)
                        report_mismatch($sformatf("message_type %0h, expected %0h",
                                                  o_message_type, want.message_type));
                    if (o_payload_length !== want.payload_length)
                        report_mismatch($sformatf("payload_length %0h, expected %0h",
                                                  o_payload_length, want.payload_length));
                end
            end
            if (i_in_valid && o_in_ready === 1'b1) begin
                decode_byte(i_data_byte, i_buffer_end);
            end
            byte_taken <= i_in_valid && o_in_ready === 1'b1;
        end
    end

    // Main sequence: reset, directed buffers, then random phases with
    // different register settings and idling.
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_MAGIC;
        i_cfg_data   = 32'h0;
        i_in_valid   = 1'b0;
        i_data_byte  = 8'h00;
        i_buffer_end = 1'b0;
        i_out_ready  = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed buffers under the reset register values.
        queue_frame(magic_reg, version_reg, 32'd0, 0, 1'b1, 0, 0);
        queue_frame(magic_reg, version_reg, 32'd3, 3, 1'b1, 2, 0);
        queue_frame(magic_reg, version_reg, 32'd1, 1, 1'b0, 0, 0);
        queue_frame(32'hFFFF_FFFF, 8'hFE, 32'd2, 2, 1'b1, 0, 0);
        queue_frame(magic_reg, 8'hFF, 32'd0, 0, 1'b1, 1, 0);
        push_buffer('{8'hFF});
        queue_frame(32'hFFFF_FFFF, 8'h00, 32'd4, 4, 1'b1, 0, 6);
        queue_frame(magic_reg, version_reg, 32'hFFFF_FFFF, 2, 1'b1, 0, 0);
        run_phase(0, 0, 390);

        write_reg(REG_MAGIC, 32'hFFFF_FFFF);
        write_reg(REG_VERSION, {24'($urandom), 8'hFF});
        run_phase(51, 0, 390);

        write_reg(REG_MAGIC, $urandom);
        write_reg(REG_VERSION, {24'($urandom), 8'h00});
        run_phase(0, 51, 390);

        write_reg(REG_MAGIC, $urandom);
        write_reg(REG_VERSION, $urandom);
        run_phase(8, 8, 390);

        write_reg(REG_MAGIC, 32'h0000_0000);
        write_reg(REG_VERSION, $urandom);
        run_phase(0, 0, 390);

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a lost result.
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
rtl/fdc_pkg.sv
rtl/fdc_parser.sv
rtl/fdc_skid.sv
rtl/frame_decoder_crc16_check.sv
tb/frame_decoder_crc16_check_tb.sv
